@@ rtl/xcfr_pkg.sv @@
// Shared types, codes and constants of the XMODEM-CRC frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package xcfr_pkg;

    localparam int MAX_FRAME_LEN = 2048;
    localparam int POS_W         = $clog2(MAX_FRAME_LEN + 1);

    // Opcodes of an input item.
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // Kinds of a result item.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_HANDSHAKE_LIMIT = 2'd0;
    localparam logic [1:0] REG_POLL_PERIOD     = 2'd1;
    localparam logic [1:0] REG_DATA_TIMEOUT    = 2'd2;
    localparam logic [1:0] REG_MIN_FRAME_LEN   = 2'd3;

    localparam logic [15:0] RST_HANDSHAKE_LIMIT = 16'd60000;
    localparam logic [15:0] RST_POLL_PERIOD     = 16'd1000;
    localparam logic [15:0] RST_DATA_TIMEOUT    = 16'd6000;
    localparam logic [7:0]  RST_MIN_FRAME_LEN   = 8'd6;

    // Result queue between front and back, in items that carry up to two results.
    localparam int QDEPTH    = 4;
    localparam int Q_PTR_W   = $clog2(QDEPTH);
    localparam int Q_CNT_W   = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       frame_good;
        logic       end_code;
    } result_t;

    // All results caused by one input item; two marks that r1 is used too.
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } bundle_t;

endpackage
`default_nettype wire

@@ rtl/xcfr_front.sv @@
// Front end: accepts input items, keeps the session state and forms their results.
`timescale 1ns / 1ps
`default_nettype none
module xcfr_front
    import xcfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        end_of_frame,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [15:0] wr_data,
    input  wire logic        q_full,
    output logic             q_push,
    output bundle_t          q_data
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HAND,
        PH_DATA
    } phase_t;

    localparam logic [16:0]      TICK_MAX      = 17'h1FFFF;
    localparam logic [POS_W-1:0] MAX_POS       = POS_W'(MAX_FRAME_LEN);
    localparam logic [POS_W-1:0] PAY_START_POS = POS_W'(5);
    localparam logic [15:0]      CRC_POLY      = 16'h1021;
    localparam logic [7:0]       B_ACK         = 8'h06;
    localparam logic [7:0]       B_NAK         = 8'h15;
    localparam logic [7:0]       B_POLL        = 8'h43;
    localparam logic [7:0]       B_EOT         = 8'h04;
    localparam logic [7:0]       B_CAN         = 8'h18;

    phase_t           phase_reg, phase_next;
    logic [16:0]      tick_reg, tick_next;
    logic [15:0]      poll_reg, poll_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       d0_reg, d0_next;
    logic [7:0]       d1_reg, d1_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      hs_limit_reg, poll_period_reg, data_timeout_reg;
    logic [7:0]       min_len_reg;

    logic    accept;
    logic    pay, has_e0, has_e1;
    result_t pay_r, e0_r, e1_r;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic result_t mk(input logic [1:0] kind, input logic [7:0] value,
                                   input logic good, input logic code);
        result_t r;
        r.kind       = kind;
        r.value      = value;
        r.frame_good = good;
        r.end_code   = code;
        return r;
    endfunction

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        logic [POS_W-1:0] pos;
        logic [7:0]       prev;
        logic [15:0]      per;
        logic             good;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        poll_next  = poll_reg;
        pos_next   = pos_reg;
        d0_next    = d0_reg;
        d1_next    = d1_reg;
        crc_next   = crc_reg;
        pay        = 1'b0;
        has_e0     = 1'b0;
        has_e1     = 1'b0;
        pay_r      = mk(KIND_PAYLOAD, d1_reg, 1'b0, 1'b0);
        e0_r       = mk(KIND_REPLY, B_NAK, 1'b0, 1'b0);
        e1_r       = mk(KIND_END, 8'h00, 1'b0, 1'b0);
        pos        = '0;
        prev       = '0;
        per        = '0;
        good       = 1'b0;
        unique case (opcode)
            OP_START:
            begin
                phase_next = PH_HAND;
                tick_next  = '0;
                poll_next  = '0;
                pos_next   = '0;
                d0_next    = '0;
                d1_next    = '0;
                crc_next   = '0;
            end
            OP_TICK:
            begin
                if (phase_reg == PH_HAND)
                begin
                    if (tick_next != TICK_MAX)
                        tick_next = tick_next + 17'd1;
                    if (tick_next > {1'b0, hs_limit_reg})
                    begin
                        phase_next = PH_DATA;
                        tick_next  = '0;
                        pos_next   = '0;
                        d0_next    = '0;
                        d1_next    = '0;
                        crc_next   = '0;
                    end
                    else
                    begin
                        per       = (poll_period_reg == 16'd0) ? 16'd1 : poll_period_reg;
                        poll_next = poll_reg + 16'd1;
                        if (poll_next >= per)
                        begin
                            poll_next = '0;
                            has_e0    = 1'b1;
                            e0_r      = mk(KIND_REPLY, B_POLL, 1'b0, 1'b0);
                        end
                    end
                end
                else if (phase_reg == PH_DATA)
                begin
                    if (tick_next != TICK_MAX)
                        tick_next = tick_next + 17'd1;
                    if (tick_next > {1'b0, data_timeout_reg})
                    begin
                        has_e0     = 1'b1;
                        e0_r       = mk(KIND_END, 8'h00, 1'b0, 1'b1);
                        phase_next = PH_IDLE;
                        pos_next   = '0;
                        d0_next    = '0;
                        d1_next    = '0;
                        crc_next   = '0;
                    end
                end
            end
            OP_BYTE:
            begin
                // A byte ends the handshake and starts the first frame.
                if (phase_reg == PH_HAND)
                begin
                    phase_next = PH_DATA;
                    tick_next  = '0;
                    pos_next   = '0;
                    d0_next    = '0;
                    d1_next    = '0;
                    crc_next   = '0;
                end
                if (phase_next == PH_DATA)
                begin
                    pos  = pos_next;
                    prev = d0_next;
                    if (pos != MAX_POS)
                    begin
                        // The two newest bytes are held back: they may be the CRC.
                        if (pos >= PAY_START_POS)
                        begin
                            pay      = 1'b1;
                            pay_r    = mk(KIND_PAYLOAD, d1_next, 1'b0, 1'b0);
                            crc_next = crc_byte(crc_next, d1_next);
                        end
                        d1_next  = d0_next;
                        d0_next  = rx_byte;
                        pos_next = pos + POS_W'(1);
                    end
                    if (end_of_frame)
                    begin
                        if (pos == MAX_POS)
                        begin
                            has_e0    = 1'b1;
                            e0_r      = mk(KIND_REPLY, B_NAK, 1'b0, 1'b0);
                            tick_next = '0;
                        end
                        else if (pos == '0)
                        begin
                            if (rx_byte == B_EOT || rx_byte == B_CAN)
                            begin
                                has_e0     = 1'b1;
                                has_e1     = 1'b1;
                                e0_r       = mk(KIND_REPLY, B_ACK, 1'b0, 1'b0);
                                e1_r       = mk(KIND_END, 8'h00, 1'b0, 1'b0);
                                phase_next = PH_IDLE;
                            end
                            tick_next = '0;
                        end
                        else if (({1'b0, pos} + (POS_W+1)'(1)) < (POS_W+1)'(min_len_reg))
                        begin
                            has_e0 = 1'b1;
                            e0_r   = mk(KIND_REPLY, B_NAK, 1'b0, 1'b0);
                        end
                        else
                        begin
                            good      = ({rx_byte, prev} == crc_next);
                            has_e0    = 1'b1;
                            e0_r      = mk(KIND_REPLY, good ? B_ACK : B_NAK, good, 1'b0);
                            tick_next = '0;
                        end
                        pos_next = '0;
                        d0_next  = '0;
                        d1_next  = '0;
                        crc_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        q_push = accept && (pay || has_e0);
        if (pay)
        begin
            q_data.two = has_e0;
            q_data.r0  = pay_r;
            q_data.r1  = e0_r;
        end
        else
        begin
            q_data.two = has_e1;
            q_data.r0  = e0_r;
            q_data.r1  = e1_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            tick_reg         <= '0;
            poll_reg         <= '0;
            pos_reg          <= '0;
            d0_reg           <= '0;
            d1_reg           <= '0;
            crc_reg          <= '0;
            hs_limit_reg     <= RST_HANDSHAKE_LIMIT;
            poll_period_reg  <= RST_POLL_PERIOD;
            data_timeout_reg <= RST_DATA_TIMEOUT;
            min_len_reg      <= RST_MIN_FRAME_LEN;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                poll_reg  <= poll_next;
                pos_reg   <= pos_next;
                d0_reg    <= d0_next;
                d1_reg    <= d1_next;
                crc_reg   <= crc_next;
            end
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_HANDSHAKE_LIMIT: hs_limit_reg     <= wr_data;
                    REG_POLL_PERIOD:     poll_period_reg  <= wr_data;
                    REG_DATA_TIMEOUT:    data_timeout_reg <= wr_data;
                    REG_MIN_FRAME_LEN:   min_len_reg      <= wr_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= MAX_POS)
        else $error("frame position passed its saturation point");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (pos_reg == '0 && crc_reg == '0))
        else $error("frame state left over while no session is open");

endmodule
`default_nettype wire

@@ rtl/xcfr_fifo.sv @@
// Short queue of result bundles between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module xcfr_fifo
    import xcfr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  bundle_t   wdata,
    output logic      q_full,
    input  wire logic pop,
    output bundle_t   head,
    output logic      q_empty
);

    bundle_t            mem_reg [QDEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push, do_pop;

    assign q_full  = (count_reg == Q_CNT_W'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_push = push && !q_full;
    assign do_pop  = pop && !q_empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(QDEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + Q_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(QDEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + Q_PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + Q_CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - Q_CNT_W'(1);
        end
    end

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + Q_CNT_W'(1)))
        else $error("queue count did not follow a push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - Q_CNT_W'(1)))
        else $error("queue count did not follow a pop");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (q_empty || q_full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with the count");

endmodule
`default_nettype wire

@@ rtl/xcfr_back.sv @@
// Back end: takes bundles from the queue and hands out their results one at a time.
`timescale 1ns / 1ps
`default_nettype none
module xcfr_back
    import xcfr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  bundle_t    head,
    input  wire logic  q_empty,
    output logic       q_pop,
    output logic       empty,
    input  wire logic  pop,
    output logic [1:0] kind,
    output logic [7:0] value,
    output logic       frame_good,
    output logic       end_code,
    output logic       last
);

    // sel_reg is set while the second result of the head bundle is shown.
    logic    sel_reg;
    logic    take;
    result_t cur;

    assign empty      = q_empty;
    assign take       = pop && !q_empty;
    assign cur        = sel_reg ? head.r1 : head.r0;
    assign kind       = cur.kind;
    assign value      = cur.value;
    assign frame_good = cur.frame_good;
    assign end_code   = cur.end_code;
    assign last       = sel_reg || !head.two;
    assign q_pop      = take && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else if (take)
            sel_reg <= !last;
    end

    a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> (!q_empty && head.two))
        else $error("second result shown without a two-result bundle");

endmodule
`default_nettype wire

@@ rtl/xmodem_crc_frame_receiver_top.sv @@
// Top level of the XMODEM-CRC frame receiver: front end, result queue and back end.
// An accepted item's results are registered in the result queue and shown at its
// head once earlier results are popped. Throughput: one input item per cycle while
// full is low; results leave at one per cycle, so an item with two results takes two
// pops. The four-entry result queue sets when full rises. Reset: session idle, all
// counters and the CRC cleared, registers at their defaults, queue empty.
`timescale 1ns / 1ps
`default_nettype none
module xmodem_crc_frame_receiver_top
    import xcfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        end_of_frame,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       kind,
    output logic [7:0]       value,
    output logic             frame_good,
    output logic             end_code,
    output logic             last,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [15:0] wr_data
);

    logic    q_full, q_empty, q_push, q_pop;
    bundle_t q_wdata, q_head;

    xcfr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .rx_byte      (rx_byte),
        .end_of_frame (end_of_frame),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_wdata)
    );

    xcfr_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wdata   (q_wdata),
        .q_full  (q_full),
        .pop     (q_pop),
        .head    (q_head),
        .q_empty (q_empty)
    );

    xcfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .value      (value),
        .frame_good (frame_good),
        .end_code   (end_code),
        .last       (last)
    );

endmodule
`default_nettype wire

@@ bench/xmodem_crc_frame_receiver_top_test.sv @@
// Self-checking bench for the XMODEM-CRC frame receiver: directed sessions, then random ones.
`timescale 1ns / 1ps
module xmodem_crc_frame_receiver_top_test;
    import xcfr_pkg::*;

    localparam logic [1:0]  OP_NONE   = 2'd3;
    localparam logic [7:0]  BYTE_ACK  = 8'h06;
    localparam logic [7:0]  BYTE_NAK  = 8'h15;
    localparam logic [7:0]  BYTE_POLL = 8'h43;
    localparam logic [7:0]  BYTE_EOT  = 8'h04;
    localparam logic [7:0]  BYTE_CAN  = 8'h18;
    localparam logic [7:0]  BYTE_SOH  = 8'h01;
    localparam logic [16:0] TICK_CEIL = 17'h1FFFF;

    typedef enum logic [1:0] {SESS_IDLE, SESS_HANDSHAKE, SESS_DATA} sess_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       good;
        logic       code;
        logic       last;
    } rx_result_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        push         = 1'b0;
    logic [1:0]  opcode       = OP_BYTE;
    logic [7:0]  rx_byte      = 8'h00;
    logic        end_of_frame = 1'b0;
    logic        pop          = 1'b0;
    logic        wr_en        = 1'b0;
    logic [1:0]  wr_index     = REG_HANDSHAKE_LIMIT;
    logic [15:0] wr_data      = 16'h0000;
    logic        full;
    logic        empty;
    logic [1:0]  kind;
    logic [7:0]  value;
    logic        frame_good;
    logic        end_code;
    logic        last;

    // Bench's own copy of the receiver's session state and registers.
    sess_t       sess;
    logic [16:0] tick_run;
    logic [15:0] poll_run;
    logic [11:0] frame_len;
    logic [7:0]  held_new;
    logic [7:0]  held_old;
    logic [15:0] crc_run;
    logic [15:0] hs_limit;
    logic [15:0] poll_every;
    logic [15:0] data_limit;
    logic [7:0]  min_len;

    rx_result_t  due_results[$];
    rx_result_t  want;
    logic [7:0]  frame_buf[$];
    int          fault_count  = 0;
    int          useful_items = 0;
    bit          steady       = 1'b0;

    xmodem_crc_frame_receiver_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .rx_byte      (rx_byte),
        .end_of_frame (end_of_frame),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .value        (value),
        .frame_good   (frame_good),
        .end_code     (end_code),
        .last         (last),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    always #4 clk = ~clk;

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    function automatic rx_result_t make_result(input logic [1:0] k, input logic [7:0] v,
                                               input logic g, input logic c);
        rx_result_t r;
        r.kind  = k;
        r.value = v;
        r.good  = g;
        r.code  = c;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic void forget_frame();
        frame_len = '0;
        crc_run   = '0;
        held_new  = '0;
        held_old  = '0;
    endfunction

    function automatic void reset_model();
        hs_limit   = RST_HANDSHAKE_LIMIT;
        poll_every = RST_POLL_PERIOD;
        data_limit = RST_DATA_TIMEOUT;
        min_len    = RST_MIN_FRAME_LEN;
        sess       = SESS_IDLE;
        tick_run   = '0;
        poll_run   = '0;
        forget_frame();
    endfunction

    // Works out the results of one accepted item and queues them; returns 1 when the
    // item was not simply ignored by the block.
    function automatic bit predict_item(input logic [1:0] op, input logic [7:0] b,
                                        input logic eof);
        rx_result_t  fresh[$];
        rx_result_t  r;
        int          pos;
        bit          over;
        bit          good;
        bit          effective;
        logic [7:0]  prev;
        logic [15:0] per;
        effective = (op == OP_START) || (op != OP_NONE && sess != SESS_IDLE);
        case (op)
            OP_START:
            begin
                sess     = SESS_HANDSHAKE;
                tick_run = '0;
                poll_run = '0;
                forget_frame();
            end
            OP_TICK:
            begin
                if (sess == SESS_HANDSHAKE)
                begin
                    if (tick_run < TICK_CEIL)
                        tick_run++;
                    if (tick_run > hs_limit)
                    begin
                        sess     = SESS_DATA;
                        tick_run = '0;
                        forget_frame();
                    end
                    else
                    begin
                        per = (poll_every == 16'd0) ? 16'd1 : poll_every;
                        poll_run++;
                        if (poll_run >= per)
                        begin
                            poll_run = '0;
                            fresh.push_back(make_result(KIND_REPLY, BYTE_POLL, 1'b0, 1'b0));
                        end
                    end
                end
                else if (sess == SESS_DATA)
                begin
                    if (tick_run < TICK_CEIL)
                        tick_run++;
                    if (tick_run > data_limit)
                    begin
                        fresh.push_back(make_result(KIND_END, 8'h00, 1'b0, 1'b1));
                        sess = SESS_IDLE;
                        forget_frame();
                    end
                end
            end
            OP_BYTE:
            begin
                // A byte during the handshake opens the data phase and starts the first frame.
                if (sess == SESS_HANDSHAKE)
                begin
                    sess     = SESS_DATA;
                    tick_run = '0;
                    forget_frame();
                end
                if (sess == SESS_DATA)
                begin
                    pos  = int'(frame_len);
                    over = pos >= MAX_FRAME_LEN;
                    prev = held_new;
                    // Payload lags two bytes behind so the CRC bytes never stream out.
                    if (!over)
                    begin
                        if (pos >= 5)
                        begin
                            fresh.push_back(make_result(KIND_PAYLOAD, held_old, 1'b0, 1'b0));
                            crc_run = crc16_step(crc_run, held_old);
                        end
                        held_old  = held_new;
                        held_new  = b;
                        frame_len = 12'(pos + 1);
                    end
                    if (eof)
                    begin
                        if (over)
                        begin
                            fresh.push_back(make_result(KIND_REPLY, BYTE_NAK, 1'b0, 1'b0));
                            tick_run = '0;
                        end
                        else if (pos == 0)
                        begin
                            if (b == BYTE_EOT || b == BYTE_CAN)
                            begin
                                fresh.push_back(make_result(KIND_REPLY, BYTE_ACK, 1'b0, 1'b0));
                                fresh.push_back(make_result(KIND_END, 8'h00, 1'b0, 1'b0));
                                sess = SESS_IDLE;
                            end
                            tick_run = '0;
                        end
                        else if (pos + 1 < min_len)
                            fresh.push_back(make_result(KIND_REPLY, BYTE_NAK, 1'b0, 1'b0));
                        else
                        begin
                            good = ({b, prev} == crc_run);
                            fresh.push_back(make_result(KIND_REPLY, good ? BYTE_ACK : BYTE_NAK,
                                                        good, 1'b0));
                            tick_run = '0;
                        end
                        forget_frame();
                    end
                end
            end
            default:
            begin
            end
        endcase
        foreach (fresh[i])
        begin
            r      = fresh[i];
            r.last = (i == fresh.size() - 1);
            due_results.push_back(r);
        end
        return effective;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic eof);
        while (!steady && $urandom_range(99) < 38)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        opcode       <= op;
        rx_byte      <= b;
        end_of_frame <= eof;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (predict_item(op, b, eof))
            useful_items++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_item(OP_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_item(OP_BYTE, frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic send_partial(input int n);
        repeat (n)
            send_item(OP_BYTE, 8'($urandom), 1'b0);
    endtask

    // Header, block number and its complement, data, then the CRC low byte first.
    function automatic void build_frame(input int n_data, input bit flip);
        logic [15:0] c;
        logic [7:0]  d;
        int          at;
        frame_buf.delete();
        d = 8'($urandom);
        frame_buf.push_back(BYTE_SOH);
        frame_buf.push_back(d);
        frame_buf.push_back(~d);
        c = '0;
        repeat (n_data)
        begin
            d = 8'($urandom);
            frame_buf.push_back(d);
            c = crc16_step(c, d);
        end
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
        if (flip)
        begin
            at = $urandom_range(frame_buf.size() - 1, 3);
            frame_buf[at] = frame_buf[at] ^ (8'h01 << $urandom_range(7));
        end
    endfunction

    function automatic void build_junk_frame(input int len);
        frame_buf.delete();
        repeat (len)
            frame_buf.push_back(8'($urandom));
    endfunction

    task automatic drain_results();
        push <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] hs, input logic [15:0] pp,
                            input logic [15:0] dt, input logic [15:0] ml);
        wr_en    <= 1'b1;
        wr_index <= REG_HANDSHAKE_LIMIT;
        wr_data  <= hs;
        @(posedge clk);
        hs_limit  = hs;
        wr_index <= REG_POLL_PERIOD;
        wr_data  <= pp;
        @(posedge clk);
        poll_every = pp;
        wr_index  <= REG_DATA_TIMEOUT;
        wr_data   <= dt;
        @(posedge clk);
        data_limit = dt;
        wr_index  <= REG_MIN_FRAME_LEN;
        wr_data   <= ml;
        @(posedge clk);
        min_len = ml[7:0];
        wr_en  <= 1'b0;
    endtask

    // Idle inputs are ignored; a default session runs one good frame and ends on EOT.
    task automatic test_idle_and_defaults();
        send_item(OP_BYTE, 8'hA5, 1'b1);
        send_item(OP_TICK, 8'h5A, 1'b0);
        send_item(OP_NONE, 8'hFF, 1'b1);
        send_item(OP_START, 8'h00, 1'b0);
        send_ticks(2);
        build_frame(1, 1'b0);
        send_frame();
        send_item(OP_BYTE, BYTE_EOT, 1'b1);
        drain_results();
    endtask

    task automatic test_handshake_polls();
        set_regs(16'd4, 16'd2, 16'd3, 16'd6);
        send_item(OP_START, 8'h00, 1'b0);
        send_ticks(5);
        send_ticks(4);
        drain_results();
        // A zero poll period acts as one tick; a restart drops the partial frame.
        set_regs(16'd3, 16'd0, 16'd3, 16'd6);
        send_item(OP_START, 8'h00, 1'b0);
        send_ticks(1);
        send_partial(2);
        send_item(OP_START, 8'h00, 1'b0);
        send_ticks(4);
        send_partial(3);
        send_ticks(4);
        drain_results();
    endtask

    task automatic test_frame_cases();
        set_regs(16'd100, 16'd50, 16'd20, 16'd6);
        send_item(OP_START, 8'h00, 1'b0);
        send_item(OP_BYTE, BYTE_CAN, 1'b1);
        send_item(OP_START, 8'h00, 1'b0);
        build_junk_frame(2);
        send_frame();
        send_item(OP_BYTE, 8'h55, 1'b1);
        build_frame(2, 1'b1);
        send_frame();
        build_frame(0, 1'b0);
        send_frame();
        drain_results();
        // With a short minimum, frames under six bytes are checked against a zero CRC.
        set_regs(16'd100, 16'd50, 16'd20, 16'd2);
        send_item(OP_BYTE, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b1);
        build_frame(0, 1'b0);
        send_frame();
        send_item(OP_BYTE, 8'h12, 1'b0);
        send_item(OP_BYTE, 8'h34, 1'b1);
        send_item(OP_BYTE, BYTE_EOT, 1'b1);
        drain_results();
    endtask

    task automatic test_register_extremes();
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
        send_item(OP_START, 8'h00, 1'b0);
        send_ticks(3);
        build_frame(249, 1'b0);
        send_frame();
        build_frame(250, 1'b0);
        send_frame();
        send_item(OP_BYTE, BYTE_EOT, 1'b1);
        drain_results();
        // Upper bits of the minimum length write are dropped.
        set_regs(16'h0000, 16'h0000, 16'h0000, 16'hFF00);
        send_item(OP_START, 8'h00, 1'b0);
        send_ticks(1);
        send_item(OP_BYTE, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_BYTE, 8'h99, 1'b1);
        send_ticks(1);
        drain_results();
    endtask

    task automatic test_overlong_frame();
        set_regs(16'd10, 16'd3, 16'd30, 16'd6);
        send_item(OP_START, 8'h00, 1'b0);
        steady = 1'b1;
        build_frame(MAX_FRAME_LEN, 1'b0);
        send_frame();
        steady = 1'b0;
        send_item(OP_BYTE, BYTE_EOT, 1'b1);
        drain_results();
    endtask

    task automatic test_random_sessions();
        int         session_no;
        int         n_frames;
        int         pick;
        logic [7:0] b;
        session_no   = 0;
        useful_items = 0;
        while (useful_items < 750)
        begin
            steady = (useful_items >= 250 && useful_items < 400);
            if (session_no == 0 || $urandom_range(3) == 0)
            begin
                drain_results();
                set_regs(16'($urandom_range(12)), 16'($urandom_range(4)),
                         16'($urandom_range(15, 1)),
                         ($urandom_range(19) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(10, 2)));
            end
            session_no++;
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(3, 1))
                    send_item(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
            send_item(OP_START, 8'($urandom), 1'($urandom));
            if ($urandom_range(1) == 0)
                send_ticks($urandom_range(int'(hs_limit) + 1));
            n_frames = $urandom_range(6, 1);
            for (int f = 0; f < n_frames && sess != SESS_IDLE; f++)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                    build_frame($urandom_range(16), 1'b0);
                else if (pick < 70)
                    build_frame($urandom_range(16), 1'b1);
                else if (pick < 80)
                    build_junk_frame($urandom_range(int'(min_len) + 1, 2));
                else if (pick < 85)
                begin
                    b = 8'($urandom);
                    if (b == BYTE_EOT || b == BYTE_CAN)
                        b = b ^ 8'h80;
                    frame_buf.delete();
                    frame_buf.push_back(b);
                end
                else if (pick < 90)
                begin
                    send_partial($urandom_range(8, 1));
                    send_item(OP_START, 8'($urandom), 1'($urandom));
                    build_frame($urandom_range(8), 1'b0);
                end
                else
                begin
                    // Timeout in the middle of a frame.
                    send_partial($urandom_range(8, 1));
                    send_ticks(int'(data_limit) + 1);
                    frame_buf.delete();
                end
                send_frame();
                send_ticks($urandom_range(3));
            end
            if (sess != SESS_IDLE)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                    send_item(OP_BYTE, BYTE_EOT, 1'b1);
                else if (pick < 70)
                    send_item(OP_BYTE, BYTE_CAN, 1'b1);
                else if (pick < 90)
                    send_ticks(int'(data_limit) + 1);
            end
        end
        steady = 1'b0;
        drain_results();
    endtask

    always @(posedge clk)
        pop <= steady || ($urandom_range(99) >= 38);

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (due_results.size() == 0)
            begin
                fault_count++;
                $display("%0t ns: expected no item", $time);
                $display("%0t ns: actual   kind %0d value %02h good %0b code %0b last %0b",
                         $time, kind, value, frame_good, end_code, last);
            end
            else
            begin
                want = due_results.pop_front();
                if ({kind, value, frame_good, end_code, last} !== want)
                begin
                    fault_count++;
                    $display("%0t ns: expected kind %0d value %02h good %0b code %0b last %0b",
                             $time, want.kind, want.value, want.good, want.code, want.last);
                    $display("%0t ns: actual   kind %0d value %02h good %0b code %0b last %0b",
                             $time, kind, value, frame_good, end_code, last);
                end
            end
        end
    end

    initial
    begin
        reset_model();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_and_defaults();
        test_handshake_polls();
        test_frame_cases();
        test_register_extremes();
        test_overlong_frame();
        test_random_sessions();
        drain_results();
        if (fault_count == 0)
            $display("xmodem_crc_frame_receiver_top_test: done, clean");
        else
            $display("xmodem_crc_frame_receiver_top_test: done, errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("xmodem_crc_frame_receiver_top_test: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/xcfr_pkg.sv
rtl/xcfr_front.sv
rtl/xcfr_fifo.sv
rtl/xcfr_back.sv
rtl/xmodem_crc_frame_receiver_top.sv
bench/xmodem_crc_frame_receiver_top_test.sv
